[rtl/core/psbn_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// psbn_pkg
// Shared constants and types of the point-set bounding-box normaliser.
// ============================================================================
package psbn_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed widths of the stream fields and of the scale register.
  localparam int FIELD_BITS = 12;
  localparam int SCALE_BITS = 12;
  localparam int OUT_BITS   = 20;

  // Register reset values.
  localparam logic [SCALE_BITS-1:0] SCALE_WIDTH_RST = 12'd500;
  localparam logic                  KEEP_ASPECT_RST = 1'b1;

  // Register select, taken from address bit 2 (registers sit 4 bytes apart).
  typedef enum logic {
    REG_SCALE_WIDTH = 1'b0,
    REG_KEEP_ASPECT = 1'b1
  } psbn_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // store the incoming point and widen the box
    logic drop;   // store is full: note the lost point
    logic setup;  // latch extents and zero flags for the set
    logic rd;     // read one stored point
    logic mul;    // form the numerator of both axes
    logic step;   // one quotient bit of both dividers
    logic put;    // load the output register
    logic last;   // the word being put closes the set
    logic clear;  // empty the box and the drop flag
  } psbn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a word that is not taken this cycle
  } psbn_status_t;

endpackage

[rtl/core/psbn_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// psbn_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module psbn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/psbn_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// psbn_ctrl
// Sequencer: load phase, extent setup, then one read, multiply, divide and put pass per point.
// ============================================================================
module psbn_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_last,
  output logic                          in_ready,
  output psbn_pkg::psbn_cmd_t           cmd,
  input  psbn_pkg::psbn_status_t        status,
  output logic [$clog2(MAX_POINTS)-1:0] addr
);
  import psbn_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = COORD_BITS + SCALE_BITS + FRAC_BITS;
  localparam int SCW = $clog2(NW);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SETUP = 6'b000010,
    S_READ  = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [AW-1:0]  idx, idx_next;
  logic [SCW-1:0] step_cnt, step_cnt_next;
  logic           full;
  logic           accept;
  logic           is_last;

  assign full     = (count == CW'(MAX_POINTS));
  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign is_last  = ((CW'(idx) + CW'(1)) == count);
  assign addr     = (state == S_LOAD) ? count[AW-1:0] : idx;

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            cmd.drop = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            count_next = count + CW'(1);
          end
          if (in_last) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        idx_next   = '0;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul       = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + SCW'(1);
        if (step_cnt == SCW'(NW - 1)) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (!status.out_busy) begin
          cmd.put  = 1'b1;
          cmd.last = is_last;
          if (is_last) begin
            cmd.clear  = 1'b1;
            count_next = '0;
            state_next = S_LOAD;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      idx      <= '0;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      idx      <= idx_next;
      step_cnt <= step_cnt_next;
    end
  end

  // A final item always hands over to the emission pass.
  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> state == S_SETUP)
    else $error("final item did not start emission");

  // The emission index never runs past the points held.
  a_idx_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_MUL || state == S_DIV || state == S_PUT)
      |-> CW'(idx) < count)
    else $error("emission index beyond stored points");

  // The fill count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

[rtl/core/psbn_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// psbn_dp
// Datapath: point store, bounding box, multipliers, two dividers, output word.
// ============================================================================
module psbn_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  psbn_pkg::psbn_cmd_t               cmd,
  output psbn_pkg::psbn_status_t            status,
  input  logic [$clog2(MAX_POINTS)-1:0]     addr,
  input  logic [COORD_BITS-1:0]             x_in,
  input  logic [COORD_BITS-1:0]             y_in,
  input  logic [psbn_pkg::SCALE_BITS-1:0]   scale_width,
  input  logic                              keep_aspect,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [psbn_pkg::OUT_BITS-1:0]     out_x,
  output logic [psbn_pkg::OUT_BITS-1:0]     out_y,
  output logic                              out_zero,
  output logic                              out_drop,
  output logic                              out_last
);
  import psbn_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = COORD_BITS + SCALE_BITS;
  localparam int NW = PW + FRAC_BITS;

  logic [CB-1:0]   min_x, max_x, min_y, max_y;
  logic            drop_flag;
  logic [CB-1:0]   dx, dy;
  logic            zero_x, zero_y, zflag;
  logic [2*CB-1:0] rd_data;
  logic [CB-1:0]   rd_x, rd_y;
  logic [CB-1:0]   off_x, off_y;
  logic [PW-1:0]   prod_x, prod_y;
  logic [NW-1:0]   num_x, num_y;
  logic [CB-1:0]   rem_x, rem_y;
  logic [CB-1:0]   ex, ey, emax;
  logic [CB+NW-1:0] step_x, step_y;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  function automatic logic [CB+NW-1:0] div_step(input logic [CB-1:0] rem,
                                                input logic [NW-1:0] num,
                                                input logic [CB-1:0] d);
    logic [CB:0] part;
    logic [CB:0] diff;
    logic        ge;
    part = {rem, num[NW-1]};
    diff = part - {1'b0, d};
    ge   = (part >= {1'b0, d});
    return ge ? {diff[CB-1:0], num[NW-2:0], 1'b1}
              : {part[CB-1:0], num[NW-2:0], 1'b0};
  endfunction

  psbn_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (addr),
    .wdata ({y_in, x_in}),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign rd_x   = rd_data[CB-1:0];
  assign rd_y   = rd_data[2*CB-1:CB];
  assign off_x  = (rd_x >= min_x) ? rd_x - min_x : '0;
  assign off_y  = (rd_y >= min_y) ? rd_y - min_y : '0;
  assign prod_x = PW'(off_x) * PW'(scale_width);
  assign prod_y = PW'(off_y) * PW'(scale_width);

  assign ex   = (max_x >= min_x) ? max_x - min_x : '0;
  assign ey   = (max_y >= min_y) ? max_y - min_y : '0;
  assign emax = (ex > ey) ? ex : ey;

  assign step_x = div_step(rem_x, num_x, dx);
  assign step_y = div_step(rem_y, num_y, dy);

  assign status.out_busy = out_valid && !out_ready;

  // Bounding box and drop flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      min_x     <= '1;
      min_y     <= '1;
      max_x     <= '0;
      max_y     <= '0;
      drop_flag <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (x_in < min_x) min_x <= x_in;
        if (x_in > max_x) max_x <= x_in;
        if (y_in < min_y) min_y <= y_in;
        if (y_in > max_y) max_y <= y_in;
      end
      if (cmd.drop) begin
        drop_flag <= 1'b1;
      end
    end
  end

  // Divisors, numerators and the quotient shift registers.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (keep_aspect) begin
        dx     <= emax;
        dy     <= emax;
        zero_x <= (emax == '0);
        zero_y <= (emax == '0);
        zflag  <= (emax == '0);
      end else begin
        dx     <= ex;
        dy     <= ey;
        zero_x <= (ex == '0);
        zero_y <= (ey == '0);
        zflag  <= (ex == '0) || (ey == '0);
      end
    end
    if (cmd.mul) begin
      num_x <= NW'(prod_x) << FRAC_BITS;
      num_y <= NW'(prod_y) << FRAC_BITS;
      rem_x <= '0;
      rem_y <= '0;
    end else if (cmd.step) begin
      {rem_x, num_x} <= step_x;
      {rem_y, num_y} <= step_y;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_x    <= zero_x ? '0 : num_x[OUT_BITS-1:0];
      out_y    <= zero_y ? '0 : num_y[OUT_BITS-1:0];
      out_zero <= zflag;
      out_drop <= drop_flag;
      out_last <= cmd.last;
    end
  end

  // A waiting word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !(out_valid && !out_ready))
    else $error("output word overwritten while stalled");

  // Divisors hold still while a division runs.
  a_divisor_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> $stable(dx) && $stable(dy))
    else $error("divisor changed during division");

endmodule

[rtl/core/point_set_bbox_normalizer.sv]
`timescale 1ns / 1ps
// ============================================================================
// point_set_bbox_normalizer
// Collects a set of pen points, then emits each one moved to the bounding-box
// origin and scaled so that the box extent maps onto scale_width.
// ============================================================================
//
//  Channel | Direction | Handshake               | Contents
//  --------+-----------+-------------------------+---------------------------------
//  s_*     | in        | s_tvalid / s_tready     | one point; tlast closes the set
//  m_*     | out       | m_tvalid / m_tready     | one scaled point; tlast on last
//  APB     | in        | psel, penable, pwrite   | scale_width, keep_aspect
//
//  Loading accepts a word whenever s_tvalid is high. After the closing word
//  the block latches the extents, then takes each stored point through a
//  store read, a multiply, the restoring dividers (one quotient bit per cycle,
//  which set the rate) and a put into the output register. s_tready is low
//  from the closing word until the last result enters the output register; a
//  stalled m_tready holds the word and pauses the sequencer. Reset is
//  synchronous; the point store needs no clearing pass.
//
module point_set_bbox_normalizer #(
  parameter int MAX_POINTS = psbn_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = psbn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psbn_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] x_coord, [23:12] y_coord
  input  logic        s_tlast,   // last_point
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [19:0] scaled_x, [39:20] scaled_y
  output logic [1:0]  m_tuser,   // [0] zero_extent, [1] overflowed
  output logic        m_tlast,   // last_result
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psbn_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  logic [SCALE_BITS-1:0]       scale_width;
  logic                        keep_aspect;
  logic                        cfg_write;
  psbn_reg_t                   reg_sel;
  psbn_cmd_t                   cmd;
  psbn_status_t                status;
  logic [AW-1:0]               addr;
  logic [COORD_BITS+FIELD_BITS-1:0] x_wide, y_wide;
  logic [COORD_BITS-1:0]       x_in, y_in;
  logic [OUT_BITS-1:0]         out_x, out_y;
  logic                        out_zero, out_drop;

  // The register file: two registers four bytes apart, so address bit 2
  // selects between them and the low bits are ignored.
  assign pready    = 1'b1;
  assign reg_sel   = psbn_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_width <= SCALE_WIDTH_RST;
      keep_aspect <= KEEP_ASPECT_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SCALE_WIDTH: scale_width <= pwdata[SCALE_BITS-1:0];
        REG_KEEP_ASPECT: keep_aspect <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCALE_WIDTH: prdata = {{(32-SCALE_BITS){1'b0}}, scale_width};
      REG_KEEP_ASPECT: prdata = {31'b0, keep_aspect};
      default:         prdata = '0;
    endcase
  end

  // Coordinates arrive as 12-bit fields; they are zero-extended and then cut
  // to the internal coordinate width, which masks them when it is narrower.
  assign x_wide = {{COORD_BITS{1'b0}}, s_tdata[FIELD_BITS-1:0]};
  assign y_wide = {{COORD_BITS{1'b0}}, s_tdata[2*FIELD_BITS-1:FIELD_BITS]};
  assign x_in   = x_wide[COORD_BITS-1:0];
  assign y_in   = y_wide[COORD_BITS-1:0];

  psbn_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status),
    .addr     (addr)
  );

  psbn_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .addr        (addr),
    .x_in        (x_in),
    .y_in        (y_in),
    .scale_width (scale_width),
    .keep_aspect (keep_aspect),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_zero    (out_zero),
    .out_drop    (out_drop),
    .out_last    (m_tlast)
  );

  // Output word packing: scaled_x lowest, flags travel on tuser.
  assign m_tdata = {out_y, out_x};
  assign m_tuser = {out_drop, out_zero};

endmodule
